>>> hw/rtl/bres_pkg.sv
// ----------------------------------------------------------------------------
// bres_pkg
// Shared types and constants for the clipped Bresenham line generator.
// ----------------------------------------------------------------------------
package bres_pkg;

  localparam int unsigned SCREEN_WIDTH  = 160;
  localparam int unsigned SCREEN_HEIGHT = 128;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic        [16:0] delta_x;
    logic signed [17:0] neg_delta_y;
    logic signed [18:0] error_term;
    logic               step_x_neg;
    logic               step_y_neg;
    logic        [15:0] held_color;
    logic               active;
  } line_state_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               on_screen;
    logic        [15:0] pixel_color;
    logic               is_last;
  } pixel_t;

endpackage

>>> hw/rtl/bres_step.sv
// ----------------------------------------------------------------------------
// bres_step
// Line setup and one Bresenham step: next line state and the pixel emitted.
// ----------------------------------------------------------------------------
module bres_step
  import bres_pkg::*;
(
  input  logic               req_type,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic        [15:0] line_color,
  input  line_state_t        cur,
  output line_state_t        nxt,
  output logic               emit,
  output pixel_t             pix
);

  logic signed [16:0] diff_x;
  logic signed [16:0] diff_y;
  logic        [16:0] abs_x;
  logic        [16:0] abs_y;
  logic signed [17:0] ndy_init;
  logic signed [19:0] twice;
  logic signed [19:0] ndy_w;
  logic signed [19:0] dx_w;
  logic               move_x;
  logic               move_y;
  logic signed [18:0] add_x;
  logic signed [18:0] add_y;
  logic               last;
  logic               vis;

  // setup
  assign diff_x   = {end_x[15], end_x} - {start_x[15], start_x};
  assign diff_y   = {end_y[15], end_y} - {start_y[15], start_y};
  assign abs_x    = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
  assign abs_y    = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);
  assign ndy_init = -$signed({1'b0, abs_y});

  // step
  assign twice  = {cur.error_term[18], cur.error_term} <<< 1;
  assign ndy_w  = {{2{cur.neg_delta_y[17]}}, cur.neg_delta_y};
  assign dx_w   = {3'b000, cur.delta_x};
  assign move_x = twice >= ndy_w;
  assign move_y = twice <= dx_w;
  assign add_x  = move_x ? {cur.neg_delta_y[17], cur.neg_delta_y} : 19'sd0;
  assign add_y  = move_y ? $signed({2'b00, cur.delta_x}) : 19'sd0;

  assign last = (cur.pos_x == cur.target_x) && (cur.pos_y == cur.target_y);
  assign vis  = !cur.pos_x[15] && (cur.pos_x < 16'(SCREEN_WIDTH)) &&
                !cur.pos_y[15] && (cur.pos_y < 16'(SCREEN_HEIGHT));

  assign pix.pixel_x     = cur.pos_x;
  assign pix.pixel_y     = cur.pos_y;
  assign pix.on_screen   = vis;
  assign pix.pixel_color = cur.held_color;
  assign pix.is_last     = last;

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    case (req_type_t'(req_type))
      REQ_START: begin
        nxt.pos_x       = start_x;
        nxt.pos_y       = start_y;
        nxt.target_x    = end_x;
        nxt.target_y    = end_y;
        nxt.delta_x     = abs_x;
        nxt.neg_delta_y = ndy_init;
        nxt.error_term  = $signed({2'b00, abs_x}) + {ndy_init[17], ndy_init};
        nxt.step_x_neg  = !(start_x < end_x);
        nxt.step_y_neg  = !(start_y < end_y);
        nxt.held_color  = line_color;
        nxt.active      = 1'b1;
      end
      REQ_STEP: begin
        if (cur.active) begin
          emit = 1'b1;
          if (last) begin
            nxt.active = 1'b0;
          end else begin
            nxt.error_term = cur.error_term + add_x + add_y;
            if (move_x) begin
              nxt.pos_x = cur.step_x_neg ? cur.pos_x - 16'sd1 : cur.pos_x + 16'sd1;
            end
            if (move_y) begin
              nxt.pos_y = cur.step_y_neg ? cur.pos_y - 16'sd1 : cur.pos_y + 16'sd1;
            end
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

>>> hw/rtl/bresenham_line_clipped.sv
// ----------------------------------------------------------------------------
// bresenham_line_clipped
// Bresenham line generator with screen clipping flag.
// ----------------------------------------------------------------------------
// A start item loads endpoints and color and gives no output; each step item
// while a line is active gives one pixel, the endpoint pixel with
// out_is_last set, after which steps give nothing until the next start. One
// item is taken every cycle: each step is a single add-compare update of the
// error term and position in bres_step, between the line state register and
// the output register. A pixel shows on the output the cycle after its step
// item is taken. The output register lets a new item in while the previous
// pixel is being taken; a pixel held by a stalled output blocks the input.
module bresenham_line_clipped
  import bres_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic        [15:0] in_line_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pixel_x,
  output logic signed [15:0] out_pixel_y,
  output logic               out_on_screen,
  output logic        [15:0] out_pixel_color,
  output logic               out_is_last
);

  line_state_t state_r;
  line_state_t state_nxt;
  logic        emit;
  pixel_t      pix;
  pixel_t      pix_r;
  logic        out_valid_r;
  logic        in_acc;

  bres_step u_step (
    .req_type   (in_req_type),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .line_color (in_line_color),
    .cur        (state_r),
    .nxt        (state_nxt),
    .emit       (emit),
    .pix        (pix)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      pix_r <= pix;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pix_r.pixel_x;
  assign out_pixel_y     = pix_r.pixel_y;
  assign out_on_screen   = pix_r.on_screen;
  assign out_pixel_color = pix_r.pixel_color;
  assign out_is_last     = pix_r.is_last;

  a_no_item_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !emit |=> !out_valid_r)
    else $error("output valid after an item with no result");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit && pix.is_last |=> !state_r.active)
    else $error("line still active after last pixel");

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req_type == REQ_START) |=> state_r.active && !out_valid_r)
    else $error("start item did not load a quiet active line");

  a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.delta_x[16] && (state_r.neg_delta_y <= 18'sd0))
    else $error("delta out of range");

endmodule

>>> verif/tb_bresenham_line_clipped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_clipped
// Drives start and step items into the clipped line generator and compares
// every pixel against a cycle-free line tracer kept in the bench. Directed
// cases cover single points, full-range spans, screen edges, axis-aligned
// lines, idle steps and restarts; random lines follow, with random input gaps
// and output stalls, ending with a stretch at full rate.
// ----------------------------------------------------------------------------
module tb_bresenham_line_clipped;
  import bres_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_req_type;
  logic signed [15:0] in_start_x;
  logic signed [15:0] in_start_y;
  logic signed [15:0] in_end_x;
  logic signed [15:0] in_end_y;
  logic        [15:0] in_line_color;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_pixel_x;
  logic signed [15:0] out_pixel_y;
  logic               out_on_screen;
  logic        [15:0] out_pixel_color;
  logic               out_is_last;

  // line tracer state
  logic signed [15:0] cur_x, cur_y, end_px, end_py;
  logic        [16:0] span_x;
  logic signed [17:0] neg_span_y;
  logic signed [18:0] bres_err;
  logic               dir_x_neg, dir_y_neg, line_busy;
  logic        [15:0] line_rgb;

  pixel_t pixel_q[$];
  pixel_t due_px;
  int     errors;
  int     items_sent;
  int     quiet_cycles;
  int     stall_left;
  bit     idle_on;

  bresenham_line_clipped dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_line_color  (in_line_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_on_screen  (out_on_screen),
    .out_pixel_color(out_pixel_color),
    .out_is_last    (out_is_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void trace_line(input req_type_t kind,
                                     input logic signed [15:0] sx, sy, ex, ey,
                                     input logic [15:0] rgb);
    int     x0, y0, x1, y1, px, py, twice;
    pixel_t pix;
    x0 = sx;
    y0 = sy;
    x1 = ex;
    y1 = ey;
    if (kind == REQ_START) begin
      cur_x      = sx;
      cur_y      = sy;
      end_px     = ex;
      end_py     = ey;
      span_x     = 17'((x1 > x0) ? x1 - x0 : x0 - x1);
      neg_span_y = 18'((y1 > y0) ? y0 - y1 : y1 - y0);
      dir_x_neg  = !(x0 < x1);
      dir_y_neg  = !(y0 < y1);
      bres_err   = 19'(int'(span_x) + int'(neg_span_y));
      line_rgb   = rgb;
      line_busy  = 1'b1;
    end else if (line_busy) begin
      px = cur_x;
      py = cur_y;
      pix.pixel_x     = cur_x;
      pix.pixel_y     = cur_y;
      pix.on_screen   = px >= 0 && px < int'(SCREEN_WIDTH) &&
                        py >= 0 && py < int'(SCREEN_HEIGHT);
      pix.pixel_color = line_rgb;
      pix.is_last     = (cur_x == end_px) && (cur_y == end_py);
      pixel_q.push_back(pix);
      if (pix.is_last) begin
        line_busy = 1'b0;
      end else begin
        twice = 2 * int'(bres_err);
        if (twice >= int'(neg_span_y)) begin
          bres_err = 19'(int'(bres_err) + int'(neg_span_y));
          cur_x    = dir_x_neg ? cur_x - 16'sd1 : cur_x + 16'sd1;
        end
        if (twice <= int'(span_x)) begin
          bres_err = 19'(int'(bres_err) + int'(span_x));
          cur_y    = dir_y_neg ? cur_y - 16'sd1 : cur_y + 16'sd1;
        end
      end
    end
  endfunction

  task automatic send_item(input req_type_t kind,
                           input logic signed [15:0] sx, sy, ex, ey,
                           input logic [15:0] rgb);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_end_x      <= ex;
    in_end_y      <= ey;
    in_line_color <= rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    trace_line(kind, sx, sy, ex, ey, rgb);
    items_sent++;
  endtask

  task automatic start_line(input int sx, sy, ex, ey, input logic [15:0] rgb);
    send_item(REQ_START, 16'(sx), 16'(sy), 16'(ex), 16'(ey), rgb);
  endtask

  // step payload is ignored by the block, so it carries noise
  task automatic step_pixels(input int count);
    for (int i = 0; i < count; i++)
      send_item(REQ_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
  endtask

  task automatic test_idle_steps();
    step_pixels(2);
  endtask

  task automatic test_single_point();
    start_line(5, 5, 5, 5, 16'hFFFF);
    step_pixels(2);
  endtask

  task automatic test_extreme_spans();
    start_line(-32768, 32767, 32767, -32768, 16'h0000);
    step_pixels(3);
    start_line(32767, -32768, -32768, 32767, 16'hA5A5);
    step_pixels(2);
  endtask

  task automatic test_screen_edges();
    start_line(158, 126, 161, 129, 16'h5A5A);
    step_pixels(4);
    start_line(1, 2, -1, 0, 16'h07E0);
    step_pixels(3);
    start_line(0, 0, 0, -2, 16'hF800);
    step_pixels(3);
  endtask

  task automatic test_random_lines(input int until_items);
    int x0, y0, x1, y1, dx, dy, len, steps, pick;
    while (items_sent < until_items) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        x0  = $signed(16'($urandom));
        y0  = $signed(16'($urandom));
        x1  = $signed(16'($urandom));
        y1  = $signed(16'($urandom));
        len = $urandom_range(1, 4);
      end else begin
        x0 = $urandom_range(0, 200);
        x0 = x0 - 20;
        y0 = $urandom_range(0, 170);
        y0 = y0 - 20;
        dx = $urandom_range(0, 24);
        dy = $urandom_range(0, 24);
        x1 = x0 + dx - 12;
        y1 = y0 + dy - 12;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = ((dx > dy) ? dx : dy) + 1;
      end
      steps = len;
      if (pick == 1)
        steps = $urandom_range(0, len - 1);
      else if (pick == 2)
        steps = len + $urandom_range(1, 3);
      start_line(x0, y0, x1, y1, 16'($urandom));
      step_pixels(steps);
    end
  endtask

  task automatic test_random_noise(input int count);
    for (int i = 0; i < count; i++)
      send_item(($urandom_range(0, 3) == 0) ? REQ_START : REQ_STEP,
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
  endtask

  task automatic test_full_rate(input int until_items);
    idle_on = 1'b0;
    test_random_lines(until_items);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $error("unexpected pixel x=%0d y=%0d", out_pixel_x, out_pixel_y);
      end else begin
        due_px = pixel_q.pop_front();
        if (out_pixel_x !== due_px.pixel_x) begin
          errors++;
          $error("pixel_x: expected %0d, got %0d", due_px.pixel_x, out_pixel_x);
        end
        if (out_pixel_y !== due_px.pixel_y) begin
          errors++;
          $error("pixel_y: expected %0d, got %0d", due_px.pixel_y, out_pixel_y);
        end
        if (out_on_screen !== due_px.on_screen) begin
          errors++;
          $error("on_screen: expected %0b, got %0b", due_px.on_screen, out_on_screen);
        end
        if (out_pixel_color !== due_px.pixel_color) begin
          errors++;
          $error("pixel_color: expected %04h, got %04h",
                 due_px.pixel_color, out_pixel_color);
        end
        if (out_is_last !== due_px.is_last) begin
          errors++;
          $error("is_last: expected %0b, got %0b", due_px.is_last, out_is_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_STEP;
    in_start_x    = '0;
    in_start_y    = '0;
    in_end_x      = '0;
    in_end_y      = '0;
    in_line_color = '0;
    out_ready     = 1'b0;
    stall_left    = 0;
    quiet_cycles  = 0;
    errors        = 0;
    items_sent    = 0;
    idle_on       = 1'b1;
    cur_x         = '0;
    cur_y         = '0;
    end_px        = '0;
    end_py        = '0;
    span_x        = '0;
    neg_span_y    = '0;
    bres_err      = '0;
    dir_x_neg     = 1'b0;
    dir_y_neg     = 1'b0;
    line_busy     = 1'b0;
    line_rgb      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_steps();
    test_single_point();
    test_extreme_spans();
    test_screen_edges();
    test_random_lines(560);
    test_random_noise(60);
    test_full_rate(700);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bres_pkg.sv
hw/rtl/bres_step.sv
hw/rtl/bresenham_line_clipped.sv
verif/tb_bresenham_line_clipped.sv
